[rtl/sli_pkg.sv]
// Shared constants and quarter-wave sine table for the sine interpolator.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int ANGLE_W = 19;
  localparam int SINE_W  = 17;
  localparam int TURN_W  = 16;
  localparam int FRAC_W  = 8;

  // 2*pi in Q3.16
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [17:0] HALF_TWO_PI = 18'(411775 / 2);

  // floor(2^40 / 2*pi_q16): turn estimate is (angle * RECIP) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 40) / 64'd411775);

  localparam int QUARTER_ENTRIES_DEF = 64;

  // table holds entries 0..TABLE_LAST; larger indices saturate
  localparam int TABLE_LAST = 64;
  localparam int TIDX_W     = 7;
  localparam int TVAL_W     = 15;

  function automatic logic [TVAL_W-1:0] quarter_sine(input logic [TIDX_W-1:0] idx);
    case (idx)
      7'd0:  return 15'd0;
      7'd1:  return 15'd804;
      7'd2:  return 15'd1607;
      7'd3:  return 15'd2410;
      7'd4:  return 15'd3211;
      7'd5:  return 15'd4011;
      7'd6:  return 15'd4807;
      7'd7:  return 15'd5601;
      7'd8:  return 15'd6392;
      7'd9:  return 15'd7179;
      7'd10: return 15'd7961;
      7'd11: return 15'd8739;
      7'd12: return 15'd9511;
      7'd13: return 15'd10278;
      7'd14: return 15'd11039;
      7'd15: return 15'd11792;
      7'd16: return 15'd12539;
      7'd17: return 15'd13278;
      7'd18: return 15'd14009;
      7'd19: return 15'd14732;
      7'd20: return 15'd15446;
      7'd21: return 15'd16151;
      7'd22: return 15'd16845;
      7'd23: return 15'd17530;
      7'd24: return 15'd18204;
      7'd25: return 15'd18867;
      7'd26: return 15'd19519;
      7'd27: return 15'd20159;
      7'd28: return 15'd20787;
      7'd29: return 15'd21402;
      7'd30: return 15'd22005;
      7'd31: return 15'd22594;
      7'd32: return 15'd23170;
      7'd33: return 15'd23731;
      7'd34: return 15'd24279;
      7'd35: return 15'd24811;
      7'd36: return 15'd25329;
      7'd37: return 15'd25832;
      7'd38: return 15'd26319;
      7'd39: return 15'd26790;
      7'd40: return 15'd27245;
      7'd41: return 15'd27683;
      7'd42: return 15'd28105;
      7'd43: return 15'd28510;
      7'd44: return 15'd28898;
      7'd45: return 15'd29268;
      7'd46: return 15'd29621;
      7'd47: return 15'd29956;
      7'd48: return 15'd30273;
      7'd49: return 15'd30571;
      7'd50: return 15'd30852;
      7'd51: return 15'd31113;
      7'd52: return 15'd31356;
      7'd53: return 15'd31580;
      7'd54: return 15'd31785;
      7'd55: return 15'd31971;
      7'd56: return 15'd32137;
      7'd57: return 15'd32285;
      7'd58: return 15'd32412;
      7'd59: return 15'd32521;
      7'd60: return 15'd32609;
      7'd61: return 15'd32678;
      7'd62: return 15'd32728;
      7'd63: return 15'd32757;
      7'd64: return 15'd32767;
      default: return 15'd32767;
    endcase
  endfunction

endpackage

[rtl/sli_turn_div.sv]
// Angle to 16-bit turn fraction: rounded divide by 2*pi via reciprocal multiply.
`timescale 1ns / 1ps

module sli_turn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [sli_pkg::ANGLE_W-1:0] in_angle,
  output logic                        turn_vld,
  output logic [sli_pkg::TURN_W-1:0]  turn
);

  localparam int PROD_W = sli_pkg::ANGLE_W + sli_pkg::RECIP_W;
  localparam int Q_W    = PROD_W - sli_pkg::RECIP_SHIFT;
  localparam int NUM_W  = sli_pkg::ANGLE_W + 17;

  // stage a: reciprocal product
  logic              vld_a_r;
  logic [PROD_W-1:0] prod_a_r;
  logic [sli_pkg::ANGLE_W-1:0] ang_a_r;

  // stage b: estimate, its back-product and the rounded numerator
  logic             vld_b_r;
  logic [Q_W-1:0]   q0_b_r;
  logic [NUM_W-1:0] qd_b_r;
  logic [NUM_W-1:0] num_b_r;

  // stage c: corrected turn
  logic                       vld_c_r;
  logic [sli_pkg::TURN_W-1:0] turn_c_r;

  logic [Q_W-1:0]   q0_nxt;
  logic [NUM_W-1:0] num_nxt;
  logic [NUM_W-1:0] rem;
  logic [Q_W-1:0]   q_fix;

  assign q0_nxt  = prod_a_r[sli_pkg::RECIP_SHIFT +: Q_W];
  assign num_nxt = {ang_a_r, 16'd0} + NUM_W'(sli_pkg::HALF_TWO_PI);
  // estimate is low by at most one
  assign rem     = num_b_r - qd_b_r;
  assign q_fix   = (rem >= NUM_W'(sli_pkg::TWO_PI_Q16)) ? q0_b_r + Q_W'(1) : q0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_a_r <= PROD_W'(in_angle) * PROD_W'(sli_pkg::RECIP);
    ang_a_r  <= in_angle;
    q0_b_r   <= q0_nxt;
    qd_b_r   <= NUM_W'(q0_nxt) * NUM_W'(sli_pkg::TWO_PI_Q16);
    num_b_r  <= num_nxt;
    turn_c_r <= q_fix[sli_pkg::TURN_W-1:0];
  end

  assign turn_vld = vld_c_r;
  assign turn     = turn_c_r;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_b_r |-> (rem < NUM_W'(2 * 411775)))
    else $error("turn remainder out of correction range");
`endif

endmodule

[rtl/sine_lut_interpolator.sv]
// Top level: pipelined sine by quarter-wave table with linear interpolation.
`timescale 1ns / 1ps

//  channel | ports                     | meaning
//  --------+---------------------------+------------------------------------
//  input   | start, busy, in_angle     | angle, unsigned Q3.16 radians
//  result  | out_valid, out_sine       | sine, signed Q1.16, one-cycle strobe
//
// One angle per clock while busy is low; each result passes through
// seven register stages (three in the divide, four in the table and
// interpolation path). Reset is synchronous; busy is high during reset
// and until the first clock edge with reset released, then stays low. The
// receiver cannot stall, so the pipeline never holds.

module sine_lut_interpolator #(
  parameter int QUARTER_ENTRIES = sli_pkg::QUARTER_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [sli_pkg::ANGLE_W-1:0]        in_angle,
  output logic                               out_valid,
  output logic signed [sli_pkg::SINE_W-1:0]  out_sine
);

  localparam int SECTORS  = 4 * QUARTER_ENTRIES;
  localparam int SEC_W    = $clog2(SECTORS);
  localparam int IDX_W    = SEC_W + 1;
  localparam int SCALED_W = sli_pkg::TURN_W + IDX_W;
  localparam int LATENCY  = 7;
  localparam int DIFF_W   = 18;
  localparam int PROD_W   = DIFF_W + sli_pkg::FRAC_W + 1;

  logic busy_r;
  logic in_acc;

  logic                       turn_vld;
  logic [sli_pkg::TURN_W-1:0] turn;

  // stage d: sector and fraction
  logic                       vld_d_r;
  logic [SEC_W-1:0]           sec_d_r;
  logic [sli_pkg::FRAC_W-1:0] frac_d_r;

  // stage e: mirrored, signed neighbors
  logic                       vld_e_r;
  logic signed [16:0]         first_e_r;
  logic signed [16:0]         second_e_r;
  logic [sli_pkg::FRAC_W-1:0] frac_e_r;

  // stage f: slope product
  logic                       vld_f_r;
  logic signed [16:0]         first_f_r;
  logic signed [PROD_W-1:0]   prod_f_r;

  // stage g: output
  logic                       vld_g_r;
  logic signed [sli_pkg::SINE_W-1:0] sine_g_r;

  logic [SCALED_W-1:0] scaled;
  logic [IDX_W-1:0]    sec_x;
  logic [IDX_W-1:0]    idx1;
  logic [IDX_W-1:0]    idx2;
  logic                neg;
  logic [sli_pkg::TVAL_W-1:0] tv1;
  logic [sli_pkg::TVAL_W-1:0] tv2;
  logic signed [16:0]  first_nxt;
  logic signed [16:0]  second_nxt;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] shifted;
  logic signed [18:0]  sum;

  function automatic logic [sli_pkg::TIDX_W-1:0] sat_idx(input logic [IDX_W-1:0] i);
    if (i > IDX_W'(sli_pkg::TABLE_LAST))
      return sli_pkg::TIDX_W'(sli_pkg::TABLE_LAST);
    else
      return sli_pkg::TIDX_W'(i);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_acc = start & ~busy_r;

  sli_turn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_angle (in_angle),
    .turn_vld (turn_vld),
    .turn     (turn)
  );

  assign scaled = SCALED_W'(turn) * SCALED_W'(SECTORS);

  // quadrant mirror and sign
  assign sec_x = IDX_W'(sec_d_r);
  always_comb begin
    if (sec_x < IDX_W'(QUARTER_ENTRIES)) begin
      idx1 = sec_x;
      idx2 = sec_x + IDX_W'(1);
      neg  = 1'b0;
    end else if (sec_x < IDX_W'(2 * QUARTER_ENTRIES)) begin
      idx1 = IDX_W'(2 * QUARTER_ENTRIES) - sec_x;
      idx2 = IDX_W'(2 * QUARTER_ENTRIES - 1) - sec_x;
      neg  = 1'b0;
    end else if (sec_x < IDX_W'(3 * QUARTER_ENTRIES)) begin
      idx1 = sec_x - IDX_W'(2 * QUARTER_ENTRIES);
      idx2 = sec_x - IDX_W'(2 * QUARTER_ENTRIES - 1);
      neg  = 1'b1;
    end else begin
      idx1 = IDX_W'(SECTORS) - sec_x;
      idx2 = IDX_W'(SECTORS - 1) - sec_x;
      neg  = 1'b1;
    end
  end

  assign tv1        = sli_pkg::quarter_sine(sat_idx(idx1));
  assign tv2        = sli_pkg::quarter_sine(sat_idx(idx2));
  assign first_nxt  = neg ? -$signed({2'b00, tv1}) : $signed({2'b00, tv1});
  assign second_nxt = neg ? -$signed({2'b00, tv2}) : $signed({2'b00, tv2});

  assign diff    = DIFF_W'(second_e_r) - DIFF_W'(first_e_r);
  // arithmetic shift floors, as required
  assign shifted = prod_f_r >>> sli_pkg::FRAC_W;
  assign sum     = 19'(first_f_r) + 19'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
    end else begin
      vld_d_r <= turn_vld;
      vld_e_r <= vld_d_r;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    sec_d_r    <= scaled[sli_pkg::TURN_W +: SEC_W];
    frac_d_r   <= scaled[sli_pkg::TURN_W-1 -: sli_pkg::FRAC_W];
    first_e_r  <= first_nxt;
    second_e_r <= second_nxt;
    frac_e_r   <= frac_d_r;
    first_f_r  <= first_e_r;
    prod_f_r   <= PROD_W'(diff) * $signed({{(PROD_W-sli_pkg::FRAC_W){1'b0}}, frac_e_r});
    sine_g_r   <= $signed({sum[15:0], 1'b0});
  end

  assign out_valid = vld_g_r;
  assign out_sine  = sine_g_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc, LATENCY) |-> out_valid)
    else $error("request produced no result at the expected latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LATENCY))
    else $error("result strobe without a matching request");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine <= 17'sd65534 && out_sine >= -17'sd65534))
    else $error("sine out of range");

  a_interp_between: assert property (@(posedge clk) disable iff (!rst_n)
    vld_f_r |-> ((prod_f_r >= 0) == (first_f_r <= sum)))
    else $error("interpolation step has wrong direction");
`endif

endmodule
